>>> design/mbp_pkg.sv
`default_nettype none

package mbp_pkg;

    localparam logic [2:0] COUNT_NONE   = 3'd0;
    localparam logic [2:0] COUNT_ONE    = 3'd1;
    localparam logic [2:0] COUNT_TWO    = 3'd2;
    localparam logic [2:0] COUNT_PAUSED = 3'd7;

    localparam logic [7:0] STATUS_NONE  = 8'h00;
    localparam logic [7:0] STATUS_SYSEX = 8'hF0;

    // Real-time bytes: 0xF8..0xFF
    localparam logic [4:0] REALTIME_PREFIX = 5'b11111;
    localparam logic [3:0] SYSTEM_NIBBLE   = 4'hF;

    localparam logic [2:0] CHAN_NEED [8] = '{
        COUNT_TWO, COUNT_TWO, COUNT_TWO, COUNT_TWO,
        COUNT_ONE, COUNT_ONE, COUNT_TWO, COUNT_TWO
    };

    localparam logic [2:0] SYS_NEED [8] = '{
        COUNT_PAUSED, COUNT_ONE, COUNT_TWO, COUNT_ONE,
        COUNT_NONE, COUNT_NONE, COUNT_NONE, COUNT_NONE
    };

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data_first;
        logic [6:0] data_second;
    } mbp_result_t;

    function automatic logic [2:0] need_of(input logic [7:0] s);
        logic [2:0] n;
        if (s[7:4] != SYSTEM_NIBBLE)
        begin
            n = CHAN_NEED[s[6:4]];
        end
        else
        begin
            n = SYS_NEED[s[2:0]];
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> design/mbp_parse.sv
`default_nettype none

module mbp_parse (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic [7:0]           midi_byte,
    output mbp_pkg::mbp_result_t      result
);
    import mbp_pkg::*;

    logic [7:0] cs_reg, cs_next, cs_mid;
    logic [2:0] rem_reg, rem_next, rem_mid, n;
    logic [6:0] store0_reg, store0_next;
    logic [6:0] store1_reg, store1_next;

    always_comb
    begin
        cs_next     = cs_reg;
        rem_next    = rem_reg;
        store0_next = store0_reg;
        store1_next = store1_reg;
        cs_mid      = cs_reg;
        rem_mid     = rem_reg;
        n           = COUNT_NONE;
        result      = '0;
        if (midi_byte[7:3] == REALTIME_PREFIX)
        begin
            result.status = midi_byte;
        end
        else
        begin
            if (midi_byte[7])
            begin
                cs_mid  = midi_byte;
                rem_mid = need_of(midi_byte);
            end
            else if (rem_reg == COUNT_TWO)
            begin
                store0_next = midi_byte[6:0];
                rem_mid     = COUNT_ONE;
            end
            else if (rem_reg == COUNT_ONE)
            begin
                store1_next = midi_byte[6:0];
                rem_mid     = COUNT_NONE;
            end
            cs_next  = cs_mid;
            rem_next = rem_mid;
            if (midi_byte[7] && rem_mid == COUNT_PAUSED)
            begin
                result.status = midi_byte;
            end
            else if (rem_mid == COUNT_NONE)
            begin
                // message complete; reload for running status
                n        = need_of(cs_mid);
                rem_next = n;
                if (cs_mid != STATUS_NONE)
                begin
                    result.status = cs_mid;
                    if (n == COUNT_TWO)
                    begin
                        result.data_first  = store0_next;
                        result.data_second = store1_next;
                    end
                    else if (n == COUNT_ONE)
                    begin
                        result.data_first = store1_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg     <= '0;
            rem_reg    <= '0;
            store0_reg <= '0;
            store1_reg <= '0;
        end
        else if (advance)
        begin
            cs_reg     <= cs_next;
            rem_reg    <= rem_next;
            store0_reg <= store0_next;
            store1_reg <= store1_next;
        end
    end

    a_rem_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg == COUNT_NONE || rem_reg == COUNT_ONE || rem_reg == COUNT_TWO
        || rem_reg == COUNT_PAUSED)
        else $error("bytes remaining out of range");

    a_paused_sysex: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg == COUNT_PAUSED |-> cs_reg == STATUS_SYSEX)
        else $error("paused count without sysex status");

    a_realtime_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && midi_byte[7:3] == REALTIME_PREFIX
        |=> cs_reg == $past(cs_reg) && rem_reg == $past(rem_reg))
        else $error("real-time byte disturbed parse state");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.status == STATUS_NONE
        |-> result.data_first == '0 && result.data_second == '0)
        else $error("data present with no message");

endmodule

`default_nettype wire

>>> design/midi_byte_stream_parser_unit.sv
// MIDI byte parser with running status. Each byte taken on the byte channel
// yields exactly one result transaction: a completed message (status plus up
// to two data bytes), an echoed real-time byte (0xF8..0xFF), the sysex start
// 0xF0, or status 0x00 for no message. Throughput is one byte per clock
// while the result side is not stalled; a byte is held in an input register,
// the parse state is updated by combinational logic, and the result lands in
// an output register before result_valid rises. Both sides may stall freely.
`default_nettype none

module midi_byte_stream_parser_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire logic [7:0] midi_byte,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [7:0]      status,
    output logic [6:0]      data_first,
    output logic [6:0]      data_second
);
    import mbp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    mbp_result_t out_reg;
    mbp_result_t parse_result;
    logic        out_free;
    logic        advance;

    assign out_free   = !out_valid_reg || result_ready;
    assign advance    = in_valid_reg && out_free;
    assign byte_ready = !in_valid_reg || advance;

    mbp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .midi_byte (in_byte_reg),
        .result    (parse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ready)
            begin
                in_valid_reg <= byte_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            in_byte_reg <= midi_byte;
        end
        if (advance)
        begin
            out_reg <= parse_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign data_first   = out_reg.data_first;
    assign data_second  = out_reg.data_second;

endmodule

`default_nettype wire

>>> tb/midi_byte_stream_parser_unit_tb.sv
`default_nettype none

module midi_byte_stream_parser_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mbp_pkg::*;

    class midi_result_board;

        mbp_result_t awaited_results[$];
        logic [7:0]  last_status;
        logic [2:0]  bytes_left;
        logic [6:0]  data_slot[2];
        int unsigned errors;

        function new();
            last_status  = STATUS_NONE;
            bytes_left   = COUNT_NONE;
            data_slot[0] = '0;
            data_slot[1] = '0;
            errors       = 0;
        endfunction

        function logic [2:0] data_count(logic [7:0] s);
            if (s[7:4] != SYSTEM_NIBBLE)
            begin
                case (s[6:4])
                    3'd4, 3'd5: return COUNT_ONE;
                    default:    return COUNT_TWO;
                endcase
            end
            case (s[2:0])
                3'd0:       return COUNT_PAUSED;
                3'd1, 3'd3: return COUNT_ONE;
                3'd2:       return COUNT_TWO;
                default:    return COUNT_NONE;
            endcase
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // advance the parse by one accepted byte and queue the message it yields
        function void take_byte(logic [7:0] b);
            mbp_result_t msg;
            logic [2:0]  reload;
            msg = '0;
            if (b[7:3] == REALTIME_PREFIX)
            begin
                msg.status = b;
            end
            else
            begin
                if (b[7])
                begin
                    last_status = b;
                    bytes_left  = data_count(b);
                end
                else if (bytes_left == COUNT_ONE || bytes_left == COUNT_TWO)
                begin
                    data_slot[(bytes_left == COUNT_TWO) ? 0 : 1] = b[6:0];
                    bytes_left = bytes_left - 3'd1;
                end
                if (b[7] && bytes_left == COUNT_PAUSED)
                begin
                    msg.status = b;
                end
                else if (bytes_left == COUNT_NONE)
                begin
                    reload     = data_count(last_status);
                    bytes_left = reload;
                    if (last_status != STATUS_NONE)
                    begin
                        msg.status = last_status;
                        if (reload == COUNT_TWO)
                        begin
                            msg.data_first  = data_slot[0];
                            msg.data_second = data_slot[1];
                        end
                        else if (reload == COUNT_ONE)
                        begin
                            msg.data_first = data_slot[1];
                        end
                    end
                end
            end
            awaited_results.push_back(msg);
        endfunction

        function void match_result(logic [7:0] s, logic [6:0] d1, logic [6:0] d2);
            mbp_result_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %h data %h %h",
                         $time, s, d1, d2);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if ({s, d1, d2} !== want)
            begin
                $display("%0t: mismatch expected status %h data %h %h, actual %h %h %h",
                         $time, want.status, want.data_first, want.data_second,
                         s, d1, d2);
                errors++;
            end
        endfunction

    endclass

    localparam int unsigned BYTE_TOTAL  = 1775;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 300;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

    bit          clk;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_ready;
    logic [7:0]  midi_byte    = 8'h00;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [7:0]  status;
    logic [6:0]  data_first;
    logic [6:0]  data_second;

    midi_result_board board;

    int unsigned sent_count;
    int unsigned cycle_count;
    int          burst_left;
    bit          hold_go;
    bit          hold_taken;
    bit          mid_drained;
    int          hold_left;
    int          mode_left;
    rx_mode_t    rx_mode;

    midi_byte_stream_parser_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .midi_byte    (midi_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .data_first   (data_first),
        .data_second  (data_second)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("midi_byte_stream_parser_unit verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                board.take_byte(midi_byte);
            end
            if (result_valid && result_ready)
            begin
                board.match_result(status, data_first, data_second);
            end
        end
    end

    // receiver: random stall modes, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go && !hold_taken)
        begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            else
            begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:   result_ready <= 1'b1;
                RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                default:   result_ready <= (mode_left % 3 != 0);
            endcase
        end
    end

    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        byte_valid <= 1'b1;
        midi_byte  <= b;
        do
            @(posedge clk);
        while (!byte_ready);
        sent_count++;
        pace();
    endtask

    task automatic wait_drained();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    task automatic send_data();
        if ($urandom_range(0, 15) == 0)
        begin
            send_byte(8'($urandom_range(8'hF8, 8'hFF)));
        end
        send_byte(8'($urandom_range(0, 127)));
    endtask

    initial
    begin
        logic [7:0] directed[$];
        logic [7:0] head;
        logic [2:0] need;
        int         pick;
        int         reps;

        board = new();
        directed = {8'h00, 8'h7F, 8'hFF, 8'h90, 8'h00, 8'h7F, 8'h55, 8'hF8, 8'h2A,
                    8'hC5, 8'h7F, 8'hE3, 8'h00, 8'h40, 8'hF0, 8'h12, 8'h7F, 8'hF7,
                    8'h33, 8'hF1, 8'h7F, 8'hF2, 8'h01, 8'h02, 8'hF3, 8'h05};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_byte(directed[i]);
        end
        wait_drained();

        while (sent_count < BYTE_TOTAL)
        begin
            if (!hold_go && sent_count > 600)
            begin
                hold_go    = 1'b1;
                burst_left = 80;
            end
            if (!mid_drained && sent_count > 1200)
            begin
                wait_drained();
                mid_drained = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                if (pick < 10)
                begin
                    head = 8'($urandom_range(8'h80, 8'hEF));
                end
                else
                begin
                    head = 8'($urandom_range(8'hF0, 8'hF7));
                end
                send_byte(head);
                need = board.data_count(head);
                if (need == COUNT_PAUSED)
                begin
                    repeat ($urandom_range(0, 8)) send_data();
                    if ($urandom_range(0, 1) == 1)
                    begin
                        send_byte(8'hF7);
                    end
                end
                else
                begin
                    reps = $urandom_range(1, 3) * ((need == COUNT_NONE) ? 1 : int'(need));
                    repeat (reps) send_data();
                end
            end
            else if (pick < 17)
            begin
                send_byte(8'($urandom()));
            end
            else
            begin
                // message cut short by the next status
                send_byte(8'($urandom_range(8'h80, 8'hEF)));
                send_byte(8'($urandom_range(0, 127)));
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("midi_byte_stream_parser_unit verification clean");
        end
        else
        begin
            $display("midi_byte_stream_parser_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
